>>> rtl/cascaded_prescaled_reload_timers_defines.svh
// ----------------------------------------------------------------------------
// assertion macros for the cascaded reload timer block
// asserts compile out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef CASCADED_PRESCALED_RELOAD_TIMERS_DEFINES_SVH
`define CASCADED_PRESCALED_RELOAD_TIMERS_DEFINES_SVH
`ifndef SYNTH
`define CPRT_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define CPRT_ASSERT_IMPL(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`else
`define CPRT_ASSERT(label, prop)
`define CPRT_ASSERT_IMPL(label, a, b)
`endif
`endif

>>> rtl/cprt_pkg.sv
// ----------------------------------------------------------------------------
// cprt_pkg
// types and constants shared by the timer cells and the top level
// ----------------------------------------------------------------------------
package cprt_pkg;

    localparam logic [1:0] CMD_ADVANCE = 2'd0;
    localparam logic [1:0] CMD_WR_LOW  = 2'd1;
    localparam logic [1:0] CMD_WR_CTL  = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  timer_sel;
        logic [15:0] reload_value;
        logic [1:0]  prescale_sel;
        logic        cascade_mode;
        logic        irq_enable;
        logic        count_enable;
        logic [23:0] cycles;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  irq_flags;
        logic [15:0] readback0;
        logic [15:0] readback1;
        logic [15:0] readback2;
        logic [15:0] readback3;
    } out_item_t;

    // control handed from one cell to the next
    typedef struct packed {
        logic        go;
        logic        ovf;
        logic [23:0] cycles;
    } link_t;

    function automatic logic [3:0] shift_of(input logic [1:0] sel);
        logic [3:0] s;
        begin
            case (sel)
                2'd0:    s = 4'd0;
                2'd1:    s = 4'd6;
                2'd2:    s = 4'd8;
                default: s = 4'd10;
            endcase
            return s;
        end
    endfunction

endpackage

>>> rtl/cascaded_prescaled_reload_timers.sv
// ----------------------------------------------------------------------------
// cascaded_prescaled_reload_timers
// chain of reload timer cells with a result register
// ----------------------------------------------------------------------------
// A write goes from idle straight to the output state. An advance walks
// the timer cells in order, and a timer that overflows folds the excess by
// its reload period in a bit-serial remainder loop before it hands the
// advance on. One transaction is in flight at a time; stall on the input is
// high while busy.
module cascaded_prescaled_reload_timers
    import cprt_pkg::*;
#(
    parameter int NUM_TIMERS = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t    state_reg, state_next;
    logic      acc;
    link_t     links [NUM_TIMERS+1];
    logic      irqs  [NUM_TIMERS];
    logic [15:0] lows [NUM_TIMERS];
    logic [3:0]  irq_reg, irq_next;
    logic        adv_reg, adv_next;
    logic        start;
    logic [3:0]  irq_vec;

    assign acc      = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign start    = acc && in_data.cmd == CMD_ADVANCE;

    assign links[0] = '{go: start, ovf: 1'b0, cycles: in_data.cycles};

    genvar g;
    generate
        for (g = 0; g < NUM_TIMERS; g++)
        begin : g_cell
            cprt_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .wr_low   (acc && in_data.cmd == CMD_WR_LOW && 32'(in_data.timer_sel) == g),
                .wr_ctl   (acc && in_data.cmd == CMD_WR_CTL && 32'(in_data.timer_sel) == g),
                .item     (in_data),
                .link_in  (links[g]),
                .link_out (links[g+1]),
                .irq      (irqs[g]),
                .low      (lows[g])
            );
        end
    endgenerate

    always_comb
    begin
        irq_vec = '0;
        for (int i = 0; i < NUM_TIMERS && i < 4; i++)
            irq_vec[i] = irqs[i];
    end

    always_comb
    begin
        state_next = state_reg;
        irq_next   = irq_reg;
        adv_next   = adv_reg;
        case (state_reg)
            ST_IDLE:
                if (acc)
                begin
                    adv_next   = start;
                    state_next = start ? ST_RUN : ST_OUT;
                end
            ST_RUN:
                if (links[NUM_TIMERS].go)
                    state_next = ST_OUT;
            ST_OUT:
                if (!out_stall)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        irq_next = irq_vec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            irq_reg   <= '0;
            adv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            irq_reg   <= irq_next;
            adv_reg   <= adv_next;
        end
    end

    assign out_valid          = (state_reg == ST_OUT);
    assign out_data.irq_flags = adv_reg ? irq_reg : 4'd0;
    assign out_data.readback0 = lows[0];
    assign out_data.readback1 = (NUM_TIMERS > 1) ? lows[(NUM_TIMERS > 1) ? 1 : 0] : 16'd0;
    assign out_data.readback2 = (NUM_TIMERS > 2) ? lows[(NUM_TIMERS > 2) ? 2 : 0] : 16'd0;
    assign out_data.readback3 = (NUM_TIMERS > 3) ? lows[(NUM_TIMERS > 3) ? 3 : 0] : 16'd0;

`include "cascaded_prescaled_reload_timers_defines.svh"
    `CPRT_ASSERT_IMPL(a_busy_stall, state_reg != ST_IDLE, in_stall)
    `CPRT_ASSERT_IMPL(a_end_in_run, links[NUM_TIMERS].go, state_reg == ST_RUN)
    `CPRT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)

endmodule

>>> rtl/cprt_cell.sv
// ----------------------------------------------------------------------------
// cprt_cell
// one timer: registers, edge handling, prescaler and reload counter.
// an advance enters as a pulse on link_in and leaves when this timer is done
// ----------------------------------------------------------------------------
module cprt_cell
    import cprt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_low,
    input  logic        wr_ctl,
    input  in_item_t    item,
    input  link_t       link_in,
    output link_t       link_out,
    output logic        irq,
    output logic [15:0] low
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WRAP = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] low_reg, low_next;
    logic [4:0]  ctl_reg, ctl_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [9:0]  rem_reg, rem_next;
    logic [15:0] rld_reg, rld_next;
    logic        run_reg, run_next;
    logic        casc_reg, casc_next;
    logic [16:0] exc_reg, exc_next;     // overflow excess still to fold
    logic [24:0] src_reg, src_next;     // excess bits still to shift in
    logic        ovf_reg, ovf_next;
    link_t       link_reg, link_next;
    // bit counter for the reduction
    logic [4:0]  rem_cnt_reg;

    logic [3:0]  sh;
    logic [24:0] total;
    logic [24:0] ticks;
    logic [16:0] period;
    logic [15:0] cnt_start;
    logic [25:0] sum;
    logic [24:0] excess_full;

    assign sh      = shift_of(ctl_reg[1:0]);
    assign period  = 17'h10000 - {1'b0, rld_reg};

    always_comb
    begin
        state_next = state_reg;
        low_next   = low_reg;
        ctl_next   = ctl_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        rld_next   = rld_reg;
        run_next   = run_reg;
        casc_next  = casc_reg;
        exc_next   = exc_reg;
        src_next   = src_reg;
        ovf_next   = ovf_reg;
        link_next  = link_reg;
        link_next.go = 1'b0;
        total       = '0;
        ticks       = '0;
        cnt_start   = cnt_reg;
        sum         = '0;
        excess_full = '0;
        if (wr_low)
            low_next = item.reload_value;
        if (wr_ctl)
            ctl_next = {item.count_enable, item.irq_enable, item.cascade_mode,
                        item.prescale_sel};
        case (state_reg)
            ST_IDLE:
            begin
                if (link_in.go)
                begin
                    link_next.cycles = link_in.cycles;
                    ovf_next = 1'b0;
                    if (ctl_reg[4] && !run_reg)
                    begin
                        rld_next  = low_reg;
                        cnt_start = low_reg;
                        run_next  = 1'b1;
                        casc_next = ctl_reg[2];
                    end
                    if (!ctl_reg[4] && run_reg)
                    begin
                        low_next      = cnt_reg;
                        run_next      = 1'b0;
                        link_next.go  = 1'b1;
                        link_next.ovf = 1'b0;
                    end
                    else if (!ctl_reg[4])
                    begin
                        link_next.go  = 1'b1;
                        link_next.ovf = 1'b0;
                    end
                    else
                    begin
                        if (ctl_reg[4] && !run_reg)
                        begin
                            rem_next = '0;
                            total    = {15'd0, 10'd0} + {1'b0, link_in.cycles};
                        end
                        else
                            total = {15'd0, rem_reg} + {1'b0, link_in.cycles};
                        if (casc_next)
                            ticks = {24'd0, link_in.ovf};
                        else
                        begin
                            ticks    = total >> sh;
                            rem_next = total[9:0] & ((10'd1 << sh) - 10'd1);
                        end
                        sum = {10'd0, cnt_start} + {1'b0, ticks};
                        if (sum <= 26'hFFFF)
                        begin
                            cnt_next      = sum[15:0];
                            low_next      = sum[15:0];
                            link_next.go  = 1'b1;
                            link_next.ovf = 1'b0;
                        end
                        else
                        begin
                            // excess fits 25 bits; fold by period in ST_WRAP
                            excess_full = 25'(sum - 26'h10000);
                            cnt_next    = cnt_start;
                            exc_next    = '0;
                            src_next    = excess_full;
                            ovf_next    = 1'b1;
                            state_next  = ST_WRAP;
                        end
                    end
                end
            end
            ST_WRAP:
            begin
                // restoring reduction: excess mod period, one bit per cycle
                exc_next = {exc_reg[15:0], src_reg[24]};
                src_next = {src_reg[23:0], 1'b0};
                if ({exc_reg[15:0], src_reg[24]} >= period)
                    exc_next = {exc_reg[15:0], src_reg[24]} - period;
                if (rem_cnt_reg == 5'd24)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cnt_next      = 16'(({1'b0, rld_reg} + exc_reg) & 17'hFFFF);
                low_next      = 16'(({1'b0, rld_reg} + exc_reg) & 17'hFFFF);
                link_next.go  = 1'b1;
                link_next.ovf = 1'b1;
                state_next    = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_cnt_reg <= '0;
        else if (state_reg != ST_WRAP)
            rem_cnt_reg <= '0;
        else
            rem_cnt_reg <= rem_cnt_reg + 5'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            low_reg   <= '0;
            ctl_reg   <= '0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            rld_reg   <= '0;
            run_reg   <= 1'b0;
            casc_reg  <= 1'b0;
            exc_reg   <= '0;
            src_reg   <= '0;
            ovf_reg   <= 1'b0;
            link_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            low_reg   <= low_next;
            ctl_reg   <= ctl_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            rld_reg   <= rld_next;
            run_reg   <= run_next;
            casc_reg  <= casc_next;
            exc_reg   <= exc_next;
            src_reg   <= src_next;
            ovf_reg   <= ovf_next;
            link_reg  <= link_next;
        end
    end

    assign link_out = link_reg;
    assign irq      = ovf_reg & ctl_reg[3];
    assign low      = low_reg;

`include "cascaded_prescaled_reload_timers_defines.svh"
    `CPRT_ASSERT_IMPL(a_wrap_needs_run, state_reg == ST_WRAP, run_reg)
    `CPRT_ASSERT_IMPL(a_done_ovf, link_reg.go && link_reg.ovf, ovf_reg)
    `CPRT_ASSERT_IMPL(a_stop_no_ovf, link_reg.go && !run_reg, !link_reg.ovf)

endmodule

>>> test/tb_cascaded_prescaled_reload_timers.sv
// ----------------------------------------------------------------------------
// tb_cascaded_prescaled_reload_timers
// drives register writes and advance transactions into the timer chain, keeps
// a transaction-level model of the four timers and checks every result's readbacks and irq flags
// ----------------------------------------------------------------------------
module tb_cascaded_prescaled_reload_timers;
    timeunit 1ns;
    timeprecision 1ps;
    import cprt_pkg::*;

    localparam int TIMER_COUNT = 4;
    localparam int IDLE_LIMIT = 20000;
    localparam int ITEM_W = $bits(in_item_t);

    class timer_scoreboard;
        logic [15:0] low_reg [TIMER_COUNT];
        logic [4:0]  ctl_reg [TIMER_COUNT];
        logic [15:0] count [TIMER_COUNT];
        logic [9:0]  remainder [TIMER_COUNT];
        logic [15:0] reload [TIMER_COUNT];
        bit          run [TIMER_COUNT];
        bit          chained [TIMER_COUNT];
        out_item_t   pending[$];
        int          errors;

        function new();
            for (int t = 0; t < TIMER_COUNT; t++)
            begin
                low_reg[t] = '0; ctl_reg[t] = '0; count[t] = '0; remainder[t] = '0;
                reload[t] = '0; run[t] = 0; chained[t] = 0;
            end
            errors = 0;
        endfunction

        function bit bump(int t, int unsigned ticks);
            int unsigned sum;
            int unsigned period;
            sum = count[t] + ticks;
            if (sum <= 32'hFFFF)
            begin
                count[t] = sum[15:0];
                return 0;
            end
            period = 32'h10000 - reload[t];
            count[t] = 16'(reload[t] + (sum - 32'h10000) % period);
            return 1;
        endfunction

        function void note_input(in_item_t it);
            out_item_t r;
            logic [3:0] flags;
            bit prev;
            bit ovf;
            int unsigned shift;
            int unsigned total;
            flags = '0;
            prev = 0;
            if (it.cmd == CMD_WR_LOW)
                low_reg[it.timer_sel] = it.reload_value;
            else if (it.cmd == CMD_WR_CTL)
                ctl_reg[it.timer_sel] = {it.count_enable, it.irq_enable, it.cascade_mode,
                                         it.prescale_sel};
            else if (it.cmd == CMD_ADVANCE)
            begin
                for (int t = 0; t < TIMER_COUNT; t++)
                begin
                    ovf = 0;
                    if (ctl_reg[t][4] && !run[t])
                    begin
                        reload[t] = low_reg[t];
                        count[t] = low_reg[t];
                        remainder[t] = '0;
                        run[t] = 1;
                        chained[t] = ctl_reg[t][2];
                    end
                    else if (!ctl_reg[t][4] && run[t])
                    begin
                        low_reg[t] = count[t];
                        run[t] = 0;
                        prev = 0;
                        continue;
                    end
                    if (!run[t])
                    begin
                        prev = 0;
                        continue;
                    end
                    if (chained[t])
                    begin
                        if (prev)
                            ovf = bump(t, 1);
                    end
                    else
                    begin
                        case (ctl_reg[t][1:0])
                            2'd0: shift = 0;
                            2'd1: shift = 6;
                            2'd2: shift = 8;
                            default: shift = 10;
                        endcase
                        total = remainder[t] + it.cycles;
                        remainder[t] = 10'(total & ((1 << shift) - 1));
                        if ((total >> shift) > 0)
                            ovf = bump(t, total >> shift);
                    end
                    if (ovf && ctl_reg[t][3])
                        flags[t] = 1'b1;
                    prev = ovf;
                    low_reg[t] = count[t];
                end
            end
            r.irq_flags = flags;
            r.readback0 = low_reg[0];
            r.readback1 = low_reg[1];
            r.readback2 = low_reg[2];
            r.readback3 = low_reg[3];
            pending.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.irq_flags !== e.irq_flags)
            begin
                $error("irq_flags expected %h actual %h", e.irq_flags, got.irq_flags);
                errors++;
            end
            if (got.readback0 !== e.readback0)
            begin
                $error("readback0 expected %h actual %h", e.readback0, got.readback0);
                errors++;
            end
            if (got.readback1 !== e.readback1)
            begin
                $error("readback1 expected %h actual %h", e.readback1, got.readback1);
                errors++;
            end
            if (got.readback2 !== e.readback2)
            begin
                $error("readback2 expected %h actual %h", e.readback2, got.readback2);
                errors++;
            end
            if (got.readback3 !== e.readback3)
            begin
                $error("readback3 expected %h actual %h", e.readback3, got.readback3);
                errors++;
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    timer_scoreboard sb = new();
    int send_idle_pct = 20;
    int recv_stall_pct = 79;
    int quiet_cycles = 0;

    always #5 clk = ~clk;

    cascaded_prescaled_reload_timers DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(in_data);
            if (out_valid && !out_stall)
                sb.check_result(out_data);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic in_item_t rand_item();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return in_item_t'(bits[ITEM_W-1:0]);
    endfunction

    // send one transaction, with a random idle gap ahead of it
    task automatic send(in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_low(int t, logic [15:0] v);
        in_item_t it;
        it = rand_item();
        it.cmd = CMD_WR_LOW;
        it.timer_sel = 2'(t);
        it.reload_value = v;
        send(it);
    endtask

    task automatic write_ctl(int t, logic [1:0] ps, bit casc, bit irq, bit en);
        in_item_t it;
        it = rand_item();
        it.cmd = CMD_WR_CTL;
        it.timer_sel = 2'(t);
        it.prescale_sel = ps;
        it.cascade_mode = casc;
        it.irq_enable = irq;
        it.count_enable = en;
        send(it);
    endtask

    task automatic advance(logic [23:0] cyc);
        in_item_t it;
        it = rand_item();
        it.cmd = CMD_ADVANCE;
        it.cycles = cyc;
        send(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_item();
        in_item_t it;
        int r;
        logic [23:0] cyc;
        r = $urandom_range(99);
        it = rand_item();
        if (r < 12)
            it.cmd = CMD_WR_LOW;
        else if (r < 30)
            it.cmd = CMD_WR_CTL;
        else if (r < 33)
            it.cmd = CMD_UNUSED;
        else
            it.cmd = CMD_ADVANCE;
        // bias reloads high so that overflows happen often
        if (it.cmd == CMD_WR_LOW && $urandom_range(3) != 0)
            it.reload_value = 16'hFFFF - 16'($urandom_range(300));
        // cycle counts from four ranges, from small up to the full 24 bits
        case ($urandom_range(3))
            0: cyc = 24'($urandom_range(20));
            1: cyc = 24'($urandom_range(2000));
            2: cyc = 24'($urandom_range(70000));
            default: cyc = 24'($urandom);
        endcase
        it.cycles = cyc;
        send(it);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, cascade on timer 0, cascade after stopped timer
        write_low(0, 16'hFFFF);
        write_low(1, 16'hFFFE);
        write_low(2, 16'h0000);
        write_low(3, 16'hFFF0);
        write_ctl(0, 2'd0, 1'b1, 1'b1, 1'b1);
        write_ctl(1, 2'd0, 1'b0, 1'b1, 1'b1);
        write_ctl(2, 2'd1, 1'b1, 1'b1, 1'b1);
        write_ctl(3, 2'd3, 1'b1, 1'b1, 1'b1);
        advance(24'd5);
        advance(24'hFFFFFF);
        write_ctl(0, 2'd0, 1'b0, 1'b1, 1'b1);
        advance(24'd0);
        write_low(1, 16'h1234);
        advance(24'd1);
        write_ctl(1, 2'd2, 1'b0, 1'b0, 1'b1);
        advance(24'd300);
        write_ctl(2, 2'd3, 1'b0, 1'b0, 1'b0);
        advance(24'd3);
        write_ctl(0, 2'd3, 1'b0, 1'b0, 1'b0);
        advance(24'hFFFFFF);
        advance(24'd1023);
        random_item();
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle_pct = 79;
                recv_stall_pct = 20;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            for (int i = 0; i < 610; i++)
            begin
                random_item();
                if (i == 300)
                    drain();
            end
        end

        drain();
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
